@@ rtl/dcfl_pkg.sv @@
// shared types and constants of the der certificate field locator
package dcfl_pkg;

  // limits of the parser
  localparam int MaxCertBytes   = 65536;
  localparam int MaxLengthBytes = 4;

  // parse phase codes
  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhOuter   = 4'd1;
  localparam logic [3:0] PhTbs     = 4'd2;
  localparam logic [3:0] PhFirst   = 4'd3;
  localparam logic [3:0] PhVersion = 4'd4;
  localparam logic [3:0] PhSerial  = 4'd5;
  localparam logic [3:0] PhOid     = 4'd6;
  localparam logic [3:0] PhIssuer  = 4'd7;
  localparam logic [3:0] PhValid   = 4'd8;
  localparam logic [3:0] PhSubj    = 4'd9;
  localparam logic [3:0] PhKey     = 4'd10;

  // header step codes
  localparam logic [1:0] StTag  = 2'd0;
  localparam logic [1:0] StLen  = 2'd1;
  localparam logic [1:0] StLong = 2'd2;
  localparam logic [1:0] StSkip = 2'd3;

  // reported field codes
  localparam logic [2:0] FieldSerial   = 3'd0;
  localparam logic [2:0] FieldIssuer   = 3'd1;
  localparam logic [2:0] FieldValidity = 3'd2;
  localparam logic [2:0] FieldSubject  = 3'd3;
  localparam logic [2:0] FieldKeyInfo  = 3'd4;

  // tag bits that mark the optional version element
  localparam logic [7:0] VersionMask = 8'ha0;

  // configuration register addresses
  localparam logic [2:0] AddrIssuerSerialOnly = 3'd0;

  // one result from the parser core
  typedef struct packed {
    logic        valid;
    logic [2:0]  field_id;
    logic [15:0] tlv_offset;
    logic [2:0]  header_length;
    logic [15:0] content_length;
    logic        status;
    logic        last_result;
  } res_t;

endpackage

@@ rtl/dcfl_core.sv @@
// tlv header parser: state registers and a combinational byte step
module dcfl_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_i,
  input  logic [15:0]        total_length_i,
  input  logic               issuer_serial_only_i,
  output dcfl_pkg::res_t     res_o
);

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  step_q, step_d;
  logic [2:0]  long_left_q, long_left_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] region_q, region_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] tag_off_q, tag_off_d;

  // next state and result for one byte
  always_comb begin
    logic        proceed;
    logic        fail_v;
    logic        finish_v;
    logic        last_v;
    logic [2:0]  id_v;
    logic [15:0] hdr_v;
    phase_d     = phase_q;
    step_d      = step_q;
    long_left_d = long_left_q;
    offset_d    = offset_q;
    region_d    = region_q;
    acc_d       = acc_q;
    skip_d      = skip_q;
    tag_off_d   = tag_off_q;
    res_o       = '0;
    proceed     = 1'b1;
    fail_v      = 1'b0;
    finish_v    = 1'b0;
    last_v      = 1'b0;
    id_v        = dcfl_pkg::FieldKeyInfo;
    hdr_v       = '0;
    if (step_en_i) begin
      // restart on a first byte
      if (first_i) begin
        phase_d     = dcfl_pkg::PhOuter;
        step_d      = dcfl_pkg::StTag;
        long_left_d = '0;
        offset_d    = '0;
        region_d    = total_length_i;
        acc_d       = '0;
        skip_d      = '0;
        tag_off_d   = '0;
        if (32'(total_length_i) > 32'(dcfl_pkg::MaxCertBytes)) begin
          fail_v  = 1'b1;
          proceed = 1'b0;
        end
      end
      if (proceed && (phase_d != dcfl_pkg::PhIdle)) begin
        // header byte decode
        unique case (step_d)
          dcfl_pkg::StTag: begin
            if (phase_d == dcfl_pkg::PhFirst) begin
              phase_d = ((data_byte_i & dcfl_pkg::VersionMask) == dcfl_pkg::VersionMask)
                        ? dcfl_pkg::PhVersion : dcfl_pkg::PhSerial;
            end
            if ((region_d <= 16'd1) || (data_byte_i == 8'd0)) begin
              fail_v = 1'b1;
            end else begin
              tag_off_d = offset_d;
              region_d  = region_d - 16'd1;
              step_d    = dcfl_pkg::StLen;
            end
          end
          dcfl_pkg::StLen: begin
            region_d = region_d - 16'd1;
            if (data_byte_i[7]) begin
              if (data_byte_i[6:0] > 7'(dcfl_pkg::MaxLengthBytes)) begin
                fail_v = 1'b1;
              end else begin
                acc_d = '0;
                if (data_byte_i[6:0] == 7'd0) begin
                  finish_v = 1'b1;
                end else begin
                  long_left_d = data_byte_i[2:0];
                  step_d      = dcfl_pkg::StLong;
                end
              end
            end else begin
              acc_d    = {8'd0, data_byte_i};
              finish_v = 1'b1;
            end
          end
          dcfl_pkg::StLong: begin
            if (region_d == 16'd0) begin
              fail_v = 1'b1;
            end else begin
              region_d    = region_d - 16'd1;
              acc_d       = (acc_d > 16'h00ff) ? 16'hffff : {acc_d[7:0], data_byte_i};
              long_left_d = long_left_d - 3'd1;
              if (long_left_d == 3'd0) begin
                finish_v = 1'b1;
              end
            end
          end
          default: begin
            region_d = region_d - 16'd1;
            skip_d   = skip_d - 16'd1;
            if (skip_d == 16'd0) begin
              phase_d = phase_d + 4'd1;
              step_d  = dcfl_pkg::StTag;
            end
          end
        endcase

        // header complete: check length, then enter region, skip version or oid, or report field
        if (finish_v) begin
          if (acc_d > region_d) begin
            fail_v = 1'b1;
          end else begin
            step_d = dcfl_pkg::StTag;
            if ((phase_d == dcfl_pkg::PhOuter) || (phase_d == dcfl_pkg::PhTbs)) begin
              region_d = acc_d;
              phase_d  = phase_d + 4'd1;
            end else begin
              skip_d = acc_d;
              if ((phase_d == dcfl_pkg::PhVersion) || (phase_d == dcfl_pkg::PhOid)) begin
                if (acc_d == 16'd0) begin
                  phase_d = phase_d + 4'd1;
                end else begin
                  step_d = dcfl_pkg::StSkip;
                end
              end else begin
                case (phase_d)
                  dcfl_pkg::PhSerial: id_v = dcfl_pkg::FieldSerial;
                  dcfl_pkg::PhIssuer: id_v = dcfl_pkg::FieldIssuer;
                  dcfl_pkg::PhValid:  id_v = dcfl_pkg::FieldValidity;
                  dcfl_pkg::PhSubj:   id_v = dcfl_pkg::FieldSubject;
                  default:            id_v = dcfl_pkg::FieldKeyInfo;
                endcase
                hdr_v  = offset_d - tag_off_d + 16'd1;
                last_v = (id_v == dcfl_pkg::FieldKeyInfo) ||
                         ((id_v == dcfl_pkg::FieldIssuer) && issuer_serial_only_i);
                if (last_v) begin
                  phase_d = dcfl_pkg::PhIdle;
                end else if (acc_d == 16'd0) begin
                  phase_d = phase_d + 4'd1;
                end else begin
                  step_d = dcfl_pkg::StSkip;
                end
                res_o.valid          = 1'b1;
                res_o.field_id       = id_v;
                res_o.tlv_offset     = tag_off_d;
                res_o.header_length  = hdr_v[2:0];
                res_o.content_length = acc_d;
                res_o.status         = 1'b0;
                res_o.last_result    = last_v;
              end
            end
          end
        end
        offset_d = offset_d + 16'd1;
      end

      // error report ends the certificate
      if (fail_v) begin
        phase_d              = dcfl_pkg::PhIdle;
        step_d               = dcfl_pkg::StTag;
        res_o                = '0;
        res_o.valid          = 1'b1;
        res_o.tlv_offset     = proceed ? (offset_d - 16'd1) : offset_d;
        res_o.status         = 1'b1;
        res_o.last_result    = 1'b1;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dcfl_pkg::PhIdle;
      step_q      <= dcfl_pkg::StTag;
      long_left_q <= '0;
      offset_q    <= '0;
      region_q    <= '0;
      acc_q       <= '0;
      skip_q      <= '0;
      tag_off_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      long_left_q <= long_left_d;
      offset_q    <= offset_d;
      region_q    <= region_d;
      acc_q       <= acc_d;
      skip_q      <= skip_d;
      tag_off_q   <= tag_off_d;
    end
  end

  // long length count stays within the allowed byte count
  a_long_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == dcfl_pkg::StLong) |->
      ((long_left_q != 3'd0) && (32'(long_left_q) <= dcfl_pkg::MaxLengthBytes)))
    else $error("long length count out of range");

  // an idle parser always waits at a tag
  a_idle_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dcfl_pkg::PhIdle) |-> (step_q == dcfl_pkg::StTag))
    else $error("idle parser not at tag step");

  // skipping always has content left
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == dcfl_pkg::StSkip) |-> (skip_q != 16'd0))
    else $error("skip with empty count");

  // an error is always the final result
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status) |-> (res_o.last_result && (phase_d == dcfl_pkg::PhIdle)))
    else $error("error result does not end parsing");

endmodule

@@ rtl/der_certificate_field_locator_unit.sv @@
// Datapath: a byte accepted into the input register is parsed by the core,
// and its result is captured in the result register when the step fires.
// Throughput: one byte per cycle; a stalled result holds the parse step
// and so stalls the input.
// Reset: rst_ni clears the parser to idle and empties both registers;
// issuer_serial_only resets to 0.
module der_certificate_field_locator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_i,
  input  logic [15:0] total_length_i,
  // field reports
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  field_id_o,
  output logic [15:0] tlv_offset_o,
  output logic [2:0]  header_length_o,
  output logic [15:0] content_length_o,
  output logic        status_o,
  output logic        last_result_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           in_valid_q;
  logic [7:0]     byte_q;
  logic           first_q;
  logic [15:0]    total_q;
  logic           out_valid_q;
  dcfl_pkg::res_t out_q;
  dcfl_pkg::res_t res;
  logic           iso_q;
  logic           fire;
  logic           in_take;

  // handshake control
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  // input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q  <= data_byte_i;
      first_q <= first_i;
      total_q <= total_length_i;
    end
  end

  // parser
  dcfl_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .step_en_i           (fire),
    .data_byte_i         (byte_q),
    .first_i             (first_q),
    .total_length_i      (total_q),
    .issuer_serial_only_i(iso_q),
    .res_o               (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign field_id_o       = out_q.field_id;
  assign tlv_offset_o     = out_q.tlv_offset;
  assign header_length_o  = out_q.header_length;
  assign content_length_o = out_q.content_length;
  assign status_o         = out_q.status;
  assign last_result_o    = out_q.last_result;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == dcfl_pkg::AddrIssuerSerialOnly)) begin
      iso_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == dcfl_pkg::AddrIssuerSerialOnly) ? {31'd0, iso_q} : 32'd0;

endmodule
